FILE: rtl/core/small_x86_like_instruction_executor_core_macros.svh
// Assertion macros shared by the checker of the executor core.
`ifndef SMALL_X86_LIKE_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define SMALL_X86_LIKE_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and masked during reset.
`define SXIE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and masked during reset.
`define SXIE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sxie_pkg.sv
// Package with opcodes, register indexes and word layout of the executor core.
package sxie_pkg;

	typedef enum logic [4:0] {
		OP_SUBL   = 5'd0,
		OP_ADDRR  = 5'd1,
		OP_ADDIR  = 5'd2,
		OP_IMULL  = 5'd3,
		OP_SHRL   = 5'd4,
		OP_MOVRR  = 5'd5,
		OP_LOAD   = 5'd6,
		OP_STORE  = 5'd7,
		OP_MOVIR  = 5'd8,
		OP_CMPL   = 5'd9,
		OP_JE     = 5'd10,
		OP_JL     = 5'd11,
		OP_JLE    = 5'd12,
		OP_JGE    = 5'd13,
		OP_JBE    = 5'd14,
		OP_JMP    = 5'd15,
		OP_CALL   = 5'd16,
		OP_RET    = 5'd17,
		OP_PUSHL  = 5'd18,
		OP_POPL   = 5'd19,
		OP_PRINTR = 5'd20,
		OP_READR  = 5'd21
	} opcode_t;

	localparam logic [4:0] SP_IDX   = 5'd6;
	localparam logic [4:0] FLAG_IDX = 5'd16;

	localparam int F_CF_BIT = 0;
	localparam int F_ZF_BIT = 6;
	localparam int F_SF_BIT = 7;
	localparam int F_OF_BIT = 11;

	// Result word layout.
	localparam int OUT_NPC_LSB  = 0;
	localparam int OUT_PV_BIT   = 32;
	localparam int OUT_PVAL_LSB = 33;
	localparam int OUT_HALT_BIT = 65;
	localparam int OUT_WIDTH    = 72;

endpackage

FILE: rtl/core/sxie_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sxie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/small_x86_like_instruction_executor_core.sv
// Top level of the small x86-like instruction executor core.
// An accepted word is registered with its register reads, its effects with the stack read, and
// its result word in the output register at writeback, which waits while the output stalls. A
// new word is accepted only while idle or during writeback. Reset: arst_n clears all control
// state; a clearing pass zeroes every stack row, during which no instruction word is accepted.
// The general registers read as zero until written; SP resets to STACK_BYTES, flags to zero.
module small_x86_like_instruction_executor_core #(
	parameter int STACK_BYTES = 1024,
	parameter int REG_COUNT   = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,     // program_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,       // instr_word[31:0], read_value[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata        // next_pc, print_valid, print_value, halted, zero pad
);

	// Stack size is taken as a power of two so byte addresses wrap by truncation.
	localparam int RAW   = $clog2(REG_COUNT);
	localparam int ABITS = $clog2(STACK_BYTES);
	localparam int ROWS  = STACK_BYTES / 4;
	localparam int RBITS = ABITS - 2;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_E1, ST_E2} state_t;

	state_t            state_q;
	logic [RBITS-1:0]  clr_row_q;
	logic [15:0]       prog_len_q;
	logic [31:0]       pc_q;
	logic              stopped_q;
	logic [31:0]       sp_q;
	logic [31:0]       flags_q;
	logic [REG_COUNT-1:0] reg_valid_q;
	logic              wb_valid_q;
	logic [4:0]        wb_idx_q;
	logic [31:0]       wb_data_q;

	// Stage one: the accepted word while the register file read is in flight.
	logic [31:0]       instr_s1;
	logic [31:0]       rv_s1;

	// Stage two: decoded effects waiting for stack data and writeback.
	logic [31:0]       npc_s2;
	logic              ret_s2;
	logic              halt_s2;
	logic              pvalid_s2;
	logic [31:0]       pv_s2;
	logic              wr_en_s2;
	logic [4:0]        wr_idx_s2;
	logic [31:0]       wr_data_s2;
	logic              wr_mem_s2;
	logic              sp_wr_s2;
	logic [31:0]       sp_new_s2;
	logic              st_en_s2;
	logic [31:0]       st_data_s2;
	logic [ABITS-1:0]  addr_s2;

	logic              acc;
	logic              e2_go;
	logic [31:0]       rf_a_q;
	logic [31:0]       rf_b_q;
	logic [7:0]        bank_q [4];
	logic              m_tvalid_q;
	logic [71:0]       m_tdata_q;

	assign acc      = s_tvalid && s_tready;
	assign e2_go    = (state_q == ST_E2) && (!m_tvalid_q || m_tready);
	// A new word enters while the previous one writes back.
	assign s_tready = (state_q == ST_IDLE) || e2_go;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Register read with the newest writeback forwarded; SP and flags live in flops.
	function automatic logic [31:0] read_reg(input logic [4:0] idx, input logic [31:0] ram_q);
		logic [31:0] v;
		v = '0;
		if (idx == sxie_pkg::SP_IDX) begin
			v = sp_q;
		end else if (idx == sxie_pkg::FLAG_IDX) begin
			v = flags_q;
		end else if (32'(idx) < REG_COUNT) begin
			if (wb_valid_q && (wb_idx_q == idx)) begin
				v = wb_data_q;
			end else if (reg_valid_q[idx[RAW-1:0]]) begin
				v = ram_q;
			end
		end
		return v;
	endfunction

	// Row of bank b that holds one of the four bytes starting at addr.
	function automatic logic [RBITS-1:0] bank_row(input logic [ABITS-1:0] addr,
			input logic [1:0] b);
		logic [1:0]       j;
		logic [ABITS-1:0] s;
		j = b - addr[1:0];
		s = addr + ABITS'(j);
		return s[ABITS-1:2];
	endfunction

	// ---------------- Execute stage: decode and compute ----------------
	logic [4:0]       op_e1;
	logic [4:0]       r1_e1;
	logic [4:0]       r2_e1;
	logic [31:0]      imm_e1;
	logic [31:0]      va_e1;
	logic [31:0]      vb_e1;
	logic [31:0]      seq_e1;
	logic [31:0]      end_addr;
	logic [31:0]      cmp_d;
	logic [31:0]      cmp_f;
	logic [31:0]      npc_e1;
	logic             ret_e1;
	logic             halt_e1;
	logic             pvalid_e1;
	logic [31:0]      pv_e1;
	logic             wr_en_e1;
	logic [4:0]       wr_idx_e1;
	logic [31:0]      wr_data_e1;
	logic             wr_mem_e1;
	logic             sp_wr_e1;
	logic [31:0]      sp_new_e1;
	logic             st_en_e1;
	logic [31:0]      st_data_e1;
	logic [31:0]      addr_e1;
	logic             ld_e1;
	logic             jump_e1;

	assign op_e1    = instr_s1[31:27];
	assign r1_e1    = instr_s1[26:22];
	assign r2_e1    = instr_s1[21:17];
	assign imm_e1   = {{16{instr_s1[15]}}, instr_s1[15:0]};
	assign va_e1    = read_reg(r1_e1, rf_a_q);
	assign vb_e1    = read_reg(r2_e1, rf_b_q);
	assign seq_e1   = pc_q + 32'd4;
	assign end_addr = {14'd0, prog_len_q, 2'b00};
	assign cmp_d    = vb_e1 - va_e1;

	always_comb begin
		cmp_f = '0;
		cmp_f[sxie_pkg::F_OF_BIT] = ((vb_e1[31] ^ va_e1[31]) & (vb_e1[31] ^ cmp_d[31]));
		cmp_f[sxie_pkg::F_ZF_BIT] = (cmp_d == 32'd0);
		cmp_f[sxie_pkg::F_CF_BIT] = (va_e1 > vb_e1);
		cmp_f[sxie_pkg::F_SF_BIT] = cmp_d[31];
	end

	always_comb begin
		npc_e1     = seq_e1;
		ret_e1     = 1'b0;
		halt_e1    = 1'b0;
		pvalid_e1  = 1'b0;
		pv_e1      = '0;
		wr_en_e1   = 1'b0;
		wr_idx_e1  = r1_e1;
		wr_data_e1 = '0;
		wr_mem_e1  = 1'b0;
		sp_wr_e1   = 1'b0;
		sp_new_e1  = sp_q;
		st_en_e1   = 1'b0;
		st_data_e1 = '0;
		addr_e1    = '0;
		ld_e1      = 1'b0;
		jump_e1    = 1'b0;
		unique case (sxie_pkg::opcode_t'(op_e1))
			sxie_pkg::OP_SUBL: begin
				wr_en_e1   = 1'b1;
				wr_data_e1 = va_e1 - imm_e1;
			end
			sxie_pkg::OP_ADDRR: begin
				wr_en_e1   = 1'b1;
				wr_idx_e1  = r2_e1;
				wr_data_e1 = va_e1 + vb_e1;
			end
			sxie_pkg::OP_ADDIR: begin
				wr_en_e1   = 1'b1;
				wr_data_e1 = va_e1 + imm_e1;
			end
			sxie_pkg::OP_IMULL: begin
				wr_en_e1   = 1'b1;
				wr_idx_e1  = r2_e1;
				wr_data_e1 = va_e1 * vb_e1;
			end
			sxie_pkg::OP_SHRL: begin
				wr_en_e1   = 1'b1;
				wr_data_e1 = va_e1 >> 1;
			end
			sxie_pkg::OP_MOVRR: begin
				wr_en_e1   = 1'b1;
				wr_idx_e1  = r2_e1;
				wr_data_e1 = va_e1;
			end
			sxie_pkg::OP_LOAD: begin
				wr_en_e1  = 1'b1;
				wr_idx_e1 = r2_e1;
				wr_mem_e1 = 1'b1;
				ld_e1     = 1'b1;
				addr_e1   = va_e1 + imm_e1;
			end
			sxie_pkg::OP_STORE: begin
				st_en_e1   = 1'b1;
				st_data_e1 = va_e1;
				addr_e1    = vb_e1 + imm_e1;
			end
			sxie_pkg::OP_MOVIR: begin
				wr_en_e1   = 1'b1;
				wr_data_e1 = imm_e1;
			end
			sxie_pkg::OP_CMPL: begin
				wr_en_e1   = 1'b1;
				wr_idx_e1  = sxie_pkg::FLAG_IDX;
				wr_data_e1 = cmp_f;
			end
			sxie_pkg::OP_JE: jump_e1 = flags_q[sxie_pkg::F_ZF_BIT];
			sxie_pkg::OP_JL: jump_e1 = flags_q[sxie_pkg::F_SF_BIT] ^ flags_q[sxie_pkg::F_OF_BIT];
			sxie_pkg::OP_JLE: jump_e1 = (flags_q[sxie_pkg::F_SF_BIT] ^ flags_q[sxie_pkg::F_OF_BIT])
				| flags_q[sxie_pkg::F_ZF_BIT];
			sxie_pkg::OP_JGE: jump_e1 = !(flags_q[sxie_pkg::F_SF_BIT] ^ flags_q[sxie_pkg::F_OF_BIT]);
			sxie_pkg::OP_JBE: jump_e1 = flags_q[sxie_pkg::F_CF_BIT] | flags_q[sxie_pkg::F_ZF_BIT];
			sxie_pkg::OP_JMP: jump_e1 = 1'b1;
			sxie_pkg::OP_CALL: begin
				sp_wr_e1   = 1'b1;
				sp_new_e1  = sp_q - 32'd4;
				st_en_e1   = 1'b1;
				st_data_e1 = seq_e1;
				addr_e1    = sp_q - 32'd4;
				jump_e1    = 1'b1;
			end
			sxie_pkg::OP_RET: begin
				if (sp_q == 32'(STACK_BYTES)) begin
					npc_e1  = pc_q;
					halt_e1 = 1'b1;
				end else begin
					ret_e1    = 1'b1;
					ld_e1     = 1'b1;
					addr_e1   = sp_q;
					sp_wr_e1  = 1'b1;
					sp_new_e1 = sp_q + 32'd4;
				end
			end
			sxie_pkg::OP_PUSHL: begin
				sp_wr_e1   = 1'b1;
				sp_new_e1  = sp_q - 32'd4;
				st_en_e1   = 1'b1;
				st_data_e1 = va_e1;
				addr_e1    = sp_q - 32'd4;
			end
			sxie_pkg::OP_POPL: begin
				ld_e1     = 1'b1;
				addr_e1   = sp_q;
				sp_wr_e1  = 1'b1;
				sp_new_e1 = sp_q + 32'd4;
				wr_en_e1  = 1'b1;
				wr_mem_e1 = 1'b1;
			end
			sxie_pkg::OP_PRINTR: begin
				pvalid_e1 = 1'b1;
				pv_e1     = va_e1;
			end
			sxie_pkg::OP_READR: begin
				wr_en_e1   = 1'b1;
				wr_data_e1 = rv_s1;
			end
			default: begin
			end
		endcase
		if (jump_e1) begin
			npc_e1 = seq_e1 + imm_e1;
		end
		// A stopped core, or one that starts at the end address, does nothing.
		if (stopped_q || (pc_q == end_addr)) begin
			npc_e1    = pc_q;
			ret_e1    = 1'b0;
			halt_e1   = 1'b1;
			pvalid_e1 = 1'b0;
			pv_e1     = '0;
			wr_en_e1  = 1'b0;
			sp_wr_e1  = 1'b0;
			st_en_e1  = 1'b0;
			ld_e1     = 1'b0;
		end
	end

	// ---------------- Writeback stage ----------------
	logic [31:0] mem_word;
	logic [31:0] npc_f;
	logic        halt_f;
	logic [31:0] wdata_f;
	logic        rf_we;

	always_comb begin
		mem_word = '0;
		for (int j = 0; j < 4; j++) begin
			mem_word[31-8*j -: 8] = bank_q[2'(addr_s2[1:0] + 2'(j))];
		end
	end

	assign npc_f   = ret_s2 ? mem_word : npc_s2;
	assign halt_f  = halt_s2 || (npc_f == end_addr);
	assign wdata_f = wr_mem_s2 ? mem_word : wr_data_s2;
	assign rf_we   = e2_go && wr_en_s2 && (32'(wr_idx_s2) < REG_COUNT)
		&& (wr_idx_s2 != sxie_pkg::SP_IDX) && (wr_idx_s2 != sxie_pkg::FLAG_IDX);

	// Register file, duplicated so both operands are read in the same cycle.
	sxie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (wr_idx_s2[RAW-1:0]),
		.wdata (wdata_f),
		.re    (acc),
		.raddr (s_tdata[22 +: RAW]),
		.rdata (rf_a_q)
	);

	sxie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (wr_idx_s2[RAW-1:0]),
		.wdata (wdata_f),
		.re    (acc),
		.raddr (s_tdata[17 +: RAW]),
		.rdata (rf_b_q)
	);

	// Stack in four byte lanes; the byte at address a sits in lane a mod 4.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic             bk_we;
		logic [RBITS-1:0] bk_waddr;
		logic [7:0]       bk_wdata;
		logic [1:0]       bk_j;

		assign bk_j = 2'(b) - addr_s2[1:0];

		always_comb begin
			if (state_q == ST_CLEAR) begin
				bk_we    = 1'b1;
				bk_waddr = clr_row_q;
				bk_wdata = '0;
			end else begin
				bk_we    = e2_go && st_en_s2;
				bk_waddr = bank_row(addr_s2, 2'(b));
				bk_wdata = st_data_s2[31 - 8*bk_j -: 8];
			end
		end

		sxie_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
			.clk   (clk),
			.we    (bk_we),
			.waddr (bk_waddr),
			.wdata (bk_wdata),
			.re    ((state_q == ST_E1) && ld_e1),
			.raddr (bank_row(addr_e1[ABITS-1:0], 2'(b))),
			.rdata (bank_q[b])
		);
	end

	// Sequencer state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_row_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + 1'b1;
					if (clr_row_q == RBITS'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_E1;
					end
				end
				ST_E1: begin
					state_q <= ST_E2;
				end
				ST_E2: begin
					if (e2_go) begin
						state_q <= acc ? ST_E1 : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (e2_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Architectural state updated at writeback; the program length is written on cfg_we.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_len_q  <= '0;
			pc_q        <= '0;
			stopped_q   <= 1'b0;
			sp_q        <= 32'(STACK_BYTES);
			flags_q     <= '0;
			reg_valid_q <= '0;
			wb_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				prog_len_q <= cfg_wdata;
			end
			wb_valid_q <= rf_we;
			if (e2_go) begin
				pc_q      <= npc_f;
				stopped_q <= stopped_q | halt_f;
				// A pop into SP overrides the increment.
				if (wr_en_s2 && (wr_idx_s2 == sxie_pkg::SP_IDX)) begin
					sp_q <= wdata_f;
				end else if (sp_wr_s2) begin
					sp_q <= sp_new_s2;
				end
				if (wr_en_s2 && (wr_idx_s2 == sxie_pkg::FLAG_IDX)) begin
					flags_q <= wdata_f;
				end
				if (rf_we) begin
					reg_valid_q[wr_idx_s2[RAW-1:0]] <= 1'b1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			instr_s1 <= s_tdata[31:0];
			rv_s1    <= s_tdata[63:32];
		end
		if (rf_we) begin
			wb_idx_q  <= wr_idx_s2;
			wb_data_q <= wdata_f;
		end
		if (state_q == ST_E1) begin
			npc_s2     <= npc_e1;
			ret_s2     <= ret_e1;
			halt_s2    <= halt_e1;
			pvalid_s2  <= pvalid_e1;
			pv_s2      <= pv_e1;
			wr_en_s2   <= wr_en_e1;
			wr_idx_s2  <= (op_e1 == sxie_pkg::OP_POPL) ? r1_e1 : wr_idx_e1;
			wr_data_s2 <= wr_data_e1;
			wr_mem_s2  <= wr_mem_e1;
			sp_wr_s2   <= sp_wr_e1;
			sp_new_s2  <= sp_new_e1;
			st_en_s2   <= st_en_e1;
			st_data_s2 <= st_data_e1;
			addr_s2    <= addr_e1[ABITS-1:0];
		end
		if (e2_go) begin
			// From the lowest bit up: next_pc, print_valid, print_value, halted, zero pad.
			m_tdata_q <= {6'd0, halt_f, pv_s2, pvalid_s2, npc_f};
		end
	end

endmodule

FILE: rtl/core/sxie_checker.sv
// Port-level checker for the executor core and its bind statement.
`include "small_x86_like_instruction_executor_core_macros.svh"

module sxie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	logic seen_halt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_halt_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tdata[sxie_pkg::OUT_HALT_BIT]) begin
			seen_halt_q <= 1'b1;
		end
	end

	`SXIE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
	`SXIE_ASSERT_NXT(a_accept_gap, s_tvalid && s_tready, !s_tready, "words accepted back to back")
	`SXIE_ASSERT_IMP(a_halt_sticky, m_tvalid && seen_halt_q, m_tdata[sxie_pkg::OUT_HALT_BIT], "halt cleared")
	`SXIE_ASSERT_IMP(a_print_zero, m_tvalid && !m_tdata[sxie_pkg::OUT_PV_BIT], m_tdata[sxie_pkg::OUT_PVAL_LSB +: 32] == 32'd0, "print value without print")

endmodule

bind small_x86_like_instruction_executor_core sxie_checker u_sxie_checker (.*);

FILE: tb/tb_small_x86_like_instruction_executor_core.sv
// Self-checking testbench for the small x86-like instruction executor core.
module tb_small_x86_like_instruction_executor_core;
	import sxie_pkg::*;

	localparam int STACK_BYTES = 1024;
	localparam int REG_COUNT   = 17;
	localparam logic [4:0] OP_UNUSED = 5'd31;
	localparam logic [4:0] R_HIGH    = 5'd31;
	localparam logic [31:0] FLAG_OF = 32'h1 << F_OF_BIT;
	localparam logic [31:0] FLAG_ZF = 32'h1 << F_ZF_BIT;
	localparam logic [31:0] FLAG_SF = 32'h1 << F_SF_BIT;
	localparam logic [31:0] FLAG_CF = 32'h1 << F_CF_BIT;

	typedef struct packed {
		logic [31:0] npc;
		logic        pvalid;
		logic [31:0] pval;
		logic        halt;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;    // instr_word[31:0], read_value[63:32]
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;    // next_pc[31:0], print_valid[32], print_value[64:33], halted[65]

	small_x86_like_instruction_executor_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Shadow architectural state of the core.
	logic [31:0] gpr [REG_COUNT];
	logic [7:0]  stack [STACK_BYTES];
	logic [31:0] pc;
	logic        stopped;
	logic [15:0] prog_len;

	logic [63:0] pending_words[$];
	outcome_t    expected_outcomes[$];
	int          failures;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          recv_hold;

	function automatic logic [31:0] rd_reg(logic [4:0] i);
		return (i < REG_COUNT) ? gpr[i] : 32'd0;
	endfunction

	function automatic void wr_reg(logic [4:0] i, logic [31:0] v);
		if (i < REG_COUNT)
			gpr[i] = v;
	endfunction

	function automatic logic [31:0] stack_rd(logic [31:0] a);
		logic [31:0] v;
		v = 0;
		for (int k = 0; k < 4; k++)
			v = {v[23:0], stack[(a + k) % STACK_BYTES]};
		return v;
	endfunction

	function automatic void stack_wr(logic [31:0] a, logic [31:0] v);
		for (int k = 0; k < 4; k++)
			stack[(a + k) % STACK_BYTES] = v[31 - 8 * k -: 8];
	endfunction

	// Executes one instruction on the shadow state and returns its outcome.
	function automatic outcome_t execute(logic [31:0] w, logic [31:0] rv);
		outcome_t    o;
		logic [4:0]  op, r1, r2;
		logic [31:0] imm, seq, fl, a, b, d, f, sp;
		logic        jump, sf, of;
		op = w[31:27];
		r1 = w[26:22];
		r2 = w[21:17];
		imm = {{16{w[15]}}, w[15:0]};
		seq = pc + 4;
		fl = rd_reg(FLAG_IDX);
		sf = (fl & FLAG_SF) != 0;
		of = (fl & FLAG_OF) != 0;
		jump = 0;
		o = '0;
		o.npc = seq;
		if (stopped || pc == {prog_len, 2'b00}) begin
			stopped = 1;
			o.npc = pc;
			o.halt = 1;
			return o;
		end
		case (op)
			OP_SUBL:   wr_reg(r1, rd_reg(r1) - imm);
			OP_ADDRR:  wr_reg(r2, rd_reg(r1) + rd_reg(r2));
			OP_ADDIR:  wr_reg(r1, rd_reg(r1) + imm);
			OP_IMULL:  wr_reg(r2, rd_reg(r1) * rd_reg(r2));
			OP_SHRL:   wr_reg(r1, rd_reg(r1) >> 1);
			OP_MOVRR:  wr_reg(r2, rd_reg(r1));
			OP_LOAD:   wr_reg(r2, stack_rd(rd_reg(r1) + imm));
			OP_STORE:  stack_wr(rd_reg(r2) + imm, rd_reg(r1));
			OP_MOVIR:  wr_reg(r1, imm);
			OP_CMPL: begin
				a = rd_reg(r2);
				b = rd_reg(r1);
				d = a - b;
				f = 0;
				if (((a ^ b) & (a ^ d)) & 32'h8000_0000) f |= FLAG_OF;
				if (d == 0) f |= FLAG_ZF;
				if (b > a) f |= FLAG_CF;
				if (d[31]) f |= FLAG_SF;
				wr_reg(FLAG_IDX, f);
			end
			OP_JE:     jump = (fl & FLAG_ZF) != 0;
			OP_JL:     jump = sf != of;
			OP_JLE:    jump = (sf != of) || ((fl & FLAG_ZF) != 0);
			OP_JGE:    jump = sf == of;
			OP_JBE:    jump = ((fl & FLAG_CF) != 0) || ((fl & FLAG_ZF) != 0);
			OP_JMP:    jump = 1;
			OP_CALL: begin
				sp = rd_reg(SP_IDX) - 4;
				wr_reg(SP_IDX, sp);
				stack_wr(sp, seq);
				jump = 1;
			end
			OP_RET: begin
				sp = rd_reg(SP_IDX);
				if (sp == STACK_BYTES) begin
					o.npc = pc;
					o.halt = 1;
				end else begin
					o.npc = stack_rd(sp);
					wr_reg(SP_IDX, sp + 4);
				end
			end
			OP_PUSHL: begin
				// The value is read before the stack pointer moves, so a push of
				// the stack pointer stores its old value.
				a = rd_reg(r1);
				sp = rd_reg(SP_IDX) - 4;
				wr_reg(SP_IDX, sp);
				stack_wr(sp, a);
			end
			OP_POPL: begin
				sp = rd_reg(SP_IDX);
				a = stack_rd(sp);
				wr_reg(SP_IDX, sp + 4);
				wr_reg(r1, a);
			end
			OP_PRINTR: begin
				o.pvalid = 1;
				o.pval = rd_reg(r1);
			end
			OP_READR:  wr_reg(r1, rv);
			default: ;
		endcase
		if (jump)
			o.npc = seq + imm;
		if (o.npc == {prog_len, 2'b00})
			o.halt = 1;
		if (o.halt)
			stopped = 1;
		pc = o.npc;
		return o;
	endfunction

	function automatic logic [31:0] encode(logic [4:0] op, logic [4:0] r1, logic [4:0] r2,
			logic [15:0] imm);
		return {op, r1, r2, 1'b0, imm};
	endfunction

	// Queues a word for the driver together with the outcome it must produce.
	function automatic void issue(logic [31:0] w, logic [31:0] rv);
		expected_outcomes.push_back(execute(w, rv));
		pending_words.push_back({rv, w});
	endfunction

	function automatic logic [31:0] random_word();
		logic [4:0]  op, r1, r2;
		logic [15:0] imm;
		op = ($urandom_range(99) < 8) ? 5'($urandom_range(22, 31)) : 5'($urandom_range(0, 21));
		r1 = ($urandom_range(9) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
		r2 = ($urandom_range(9) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
		imm = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 63) - 32) : 16'($urandom);
		return {op, r1, r2, 1'($urandom), imm};
	endfunction

	// Random instruction that keeps the program running; one that would halt
	// is rolled back and drawn again.
	task automatic issue_running();
		logic [31:0] saved_gpr [REG_COUNT];
		logic [7:0]  saved_stack [STACK_BYTES];
		logic [31:0] saved_pc, w, rv;
		outcome_t    o;
		saved_gpr = gpr;
		saved_stack = stack;
		saved_pc = pc;
		forever begin
			w = random_word();
			rv = $urandom;
			o = execute(w, rv);
			if (!o.halt)
				break;
			gpr = saved_gpr;
			stack = saved_stack;
			pc = saved_pc;
			stopped = 0;
		end
		expected_outcomes.push_back(o);
		pending_words.push_back({rv, w});
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The register is only written while the core is idle.
	task automatic write_length(logic [15:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		prog_len = v;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Driver: offers the next queued word, idling at random. The word on the
	// bus stays at the front of the queue until it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				void'(pending_words.pop_front());
			if (pending_words.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				s_tdata <= pending_words[0];
				s_tvalid <= 1;
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// Receiver readiness, with a long hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else if (recv_hold > 0) begin
			m_tready <= 0;
			recv_hold <= recv_hold - 1;
		end else begin
			m_tready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// Monitor: each result word is checked against the oldest expectation.
	always @(posedge clk) begin
		outcome_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.npc = m_tdata[OUT_NPC_LSB +: 32];
			got.pvalid = m_tdata[OUT_PV_BIT];
			got.pval = m_tdata[OUT_PVAL_LSB +: 32];
			got.halt = m_tdata[OUT_HALT_BIT];
			if (expected_outcomes.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, m_tdata);
				failures++;
			end else begin
				want = expected_outcomes.pop_front();
				if (want != got) begin
					$display("%0t: expected npc=%h pv=%b val=%h halt=%b, got npc=%h pv=%b val=%h halt=%b",
						$time, want.npc, want.pvalid, want.pval, want.halt,
						got.npc, got.pvalid, got.pval, got.halt);
					failures++;
				end
			end
		end
	end

	initial begin
		logic [15:0] len;
		int ending;
		failures = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		for (int i = 0; i < REG_COUNT; i++)
			gpr[i] = 0;
		gpr[SP_IDX] = STACK_BYTES;
		for (int i = 0; i < STACK_BYTES; i++)
			stack[i] = 0;
		pc = 0;
		stopped = 0;
		prog_len = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// A zero length would halt at once, so the end address is moved away first.
		write_length(16'hffff);

		// Directed part: every operation, extreme fields and the corner cases.
		issue(encode(OP_MOVIR, 5'd1, 5'd0, 16'h7fff), 0);
		issue(encode(OP_MOVIR, 5'd2, 5'd0, 16'h8000), 0);
		issue(encode(OP_SUBL, 5'd1, 5'd0, 16'hffff), 0);
		issue(encode(OP_ADDRR, 5'd1, 5'd2, 16'h0), 0);
		issue(encode(OP_ADDIR, 5'd2, 5'd0, 16'h0001), 0);
		issue(encode(OP_IMULL, 5'd1, 5'd2, 16'h0), 0);
		issue(encode(OP_SHRL, 5'd2, 5'd0, 16'h0), 0);
		issue(encode(OP_MOVRR, 5'd2, 5'd3, 16'h0), 0);
		// Store and load that straddle the wrap of the stack address.
		issue(encode(OP_STORE, 5'd1, 5'd0, 16'h03fe), 0);
		issue(encode(OP_LOAD, 5'd0, 5'd4, 16'h03fe), 0);
		// Compare whose operand is the flag register itself.
		issue(encode(OP_CMPL, FLAG_IDX, 5'd1, 16'h0), 0);
		issue(encode(OP_CMPL, 5'd1, 5'd2, 16'h0), 0);
		issue(encode(OP_JE, 5'd0, 5'd0, 16'h0008), 0);
		issue(encode(OP_JL, 5'd0, 5'd0, 16'h0004), 0);
		issue(encode(OP_JLE, 5'd0, 5'd0, 16'hfffc), 0);
		issue(encode(OP_JGE, 5'd0, 5'd0, 16'h0010), 0);
		issue(encode(OP_JBE, 5'd0, 5'd0, 16'h0004), 0);
		issue(encode(OP_JMP, 5'd0, 5'd0, 16'h0020), 0);
		issue(encode(OP_CALL, 5'd0, 5'd0, 16'h0040), 0);
		issue(encode(OP_RET, 5'd0, 5'd0, 16'h0), 0);
		issue(encode(OP_PUSHL, SP_IDX, 5'd0, 16'h0), 0);
		issue(encode(OP_POPL, SP_IDX, 5'd0, 16'h0), 0);
		issue(encode(OP_READR, R_HIGH, 5'd0, 16'h0), 32'h8000_0000);
		issue(encode(OP_READR, 5'd5, 5'd0, 16'h0), 32'hffff_ffff);
		issue(encode(OP_PRINTR, 5'd5, 5'd0, 16'h0), 0);
		issue(encode(OP_PRINTR, R_HIGH, 5'd0, 16'h0), 0);
		issue({OP_UNUSED, R_HIGH, R_HIGH, 1'b1, 16'hffff}, 32'h7fff_ffff);

		// Random phases, each under a different length and idling pattern.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: len = 16'h0000;
				1: len = 16'($urandom);
				2: len = 16'hffff;
				default: len = 16'($urandom_range(1, 255));
			endcase
			// The length must not put the end address at the current pc.
			if ({len, 2'b00} == pc)
				len = len ^ 16'h1;
			write_length(len);
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 78 : 7) : 0;
			recv_stall_pct = (ph == 2) ? 78 : ((ph == 3) ? 7 : 0);
			if (ph == 0)
				recv_hold <= 300;
			for (int i = 0; i < 200; i++)
				issue_running();
		end

		// Ending: go to a known pc, then halt in one of three ways.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_length(16'hffff);
		issue(encode(OP_MOVIR, 5'd0, 5'd0, 16'h0100), 0);
		issue(encode(OP_PUSHL, 5'd0, 5'd0, 16'h0), 0);
		issue(encode(OP_RET, 5'd0, 5'd0, 16'h0), 0);
		ending = $urandom_range(2);
		if (ending == 0) begin
			write_length(16'h0040);
		end else if (ending == 1) begin
			write_length(16'h0041);
			issue({OP_UNUSED, 27'd0}, 0);
		end else begin
			issue(encode(OP_MOVIR, SP_IDX, 5'd0, 16'(STACK_BYTES)), 0);
			issue(encode(OP_RET, 5'd0, 5'd0, 16'h0), 0);
		end
		for (int i = 0; i < 6; i++)
			issue(random_word(), $urandom);

		drain();
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/sxie_pkg.sv
rtl/core/sxie_ram.sv
rtl/core/small_x86_like_instruction_executor_core.sv
rtl/core/sxie_checker.sv
tb/tb_small_x86_like_instruction_executor_core.sv
